// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and status codes of the segment intersection test.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam logic [1:0] HIT_NONE    = 2'd0;
    localparam logic [1:0] HIT_OUTSIDE = 2'd1;
    localparam logic [1:0] HIT_INSIDE  = 2'd2;

    typedef struct packed {
        logic valid;
        logic den_zero;
    } t_ctl;

endpackage

// ----- src/sit_if.sv -----
// ----------------------------------------------------------------------------
// sit_in_if / sit_out_if
// Valid/ready channels carrying segment pairs and intersection results.
// ----------------------------------------------------------------------------
interface sit_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] seg_a_start_x;
    logic signed [W-1:0] seg_a_start_y;
    logic signed [W-1:0] seg_a_end_x;
    logic signed [W-1:0] seg_a_end_y;
    logic signed [W-1:0] seg_b_start_x;
    logic signed [W-1:0] seg_b_start_y;
    logic signed [W-1:0] seg_b_end_x;
    logic signed [W-1:0] seg_b_end_y;

    modport source (
        output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
               seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
        input  ready
    );
    modport sink (
        input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
               seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
        output ready
    );
endinterface

interface sit_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] cross_x;
    logic signed [W-1:0] cross_y;
    logic [1:0]          hit_status;
    logic                saturated;

    modport source (
        output valid, cross_x, cross_y, hit_status, saturated,
        input  ready
    );
    modport sink (
        input  valid, cross_x, cross_y, hit_status, saturated,
        output ready
    );
endinterface

// ----- src/segment_intersection_test.sv -----
// Throughput: one transaction per cycle while the output is not stalled; the divider
// has COORD_WIDTH + 1 quotient stages, one bit per stage, and runs both coordinates side by side.
// The whole pipeline advances when the output register is empty or taken.
// Reset (synchronous, active low) clears the valid bits and the control register of the finish stage only.
// ----------------------------------------------------------------------------
// segment_intersection_test
// Pipelined crossing point and bounding box test of two line segments.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sit_in_if.sink      i_seg,
    sit_out_if.source   o_res
);
    localparam int W = COORD_WIDTH;

    logic                   en;
    logic [7:0][W-1:0]      coord;
    logic                   p_valid;
    logic signed [3*W+2:0]  xnum, ynum;
    logic signed [2*W+2:0]  den;
    logic [7:0][W-1:0]      p_coord, d_coord;
    sit_pkg::t_ctl          d_ctl;
    logic [W:0]             qx, qy;
    logic                   negx, negy, hix, hiy;

    assign en          = !o_res.valid || o_res.ready;
    assign i_seg.ready = en;
    assign coord = {i_seg.seg_b_end_y, i_seg.seg_b_end_x,
                    i_seg.seg_b_start_y, i_seg.seg_b_start_x,
                    i_seg.seg_a_end_y, i_seg.seg_a_end_x,
                    i_seg.seg_a_start_y, i_seg.seg_a_start_x};

    sit_products #(.W(W)) u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_seg.valid),
        .i_coord (coord),
        .o_valid (p_valid),
        .o_xnum  (xnum),
        .o_ynum  (ynum),
        .o_den   (den),
        .o_coord (p_coord)
    );

    sit_divider #(.W(W)) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_xnum  (xnum),
        .i_ynum  (ynum),
        .i_den   (den),
        .i_coord (p_coord),
        .o_ctl   (d_ctl),
        .o_qx    (qx),
        .o_qy    (qy),
        .o_negx  (negx),
        .o_negy  (negy),
        .o_hix   (hix),
        .o_hiy   (hiy),
        .o_coord (d_coord)
    );

    sit_finish #(.W(W)) u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (d_ctl),
        .i_qx    (qx),
        .i_qy    (qy),
        .i_negx  (negx),
        .i_negy  (negy),
        .i_hix   (hix),
        .i_hiy   (hiy),
        .i_coord (d_coord),
        .o_res   (o_res)
    );

    `ASSERT_IMPL(a_parallel_zero, o_res.valid && o_res.hit_status == sit_pkg::HIT_NONE, o_res.cross_x == '0 && o_res.cross_y == '0 && !o_res.saturated)
    `ASSERT_IMPL(a_sat_outside, o_res.valid && o_res.saturated, o_res.hit_status == sit_pkg::HIT_OUTSIDE)
    `ASSERT_NEXT(a_stall_freeze, o_res.valid && !o_res.ready, !i_seg.ready || o_res.ready)

endmodule

// ----- src/sit_products.sv -----
// ----------------------------------------------------------------------------
// sit_products
// Three stages: determinants and deltas, split partial products, exact sums.
// ----------------------------------------------------------------------------
module sit_products #(
    parameter int W = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [7:0][W-1:0]      i_coord,
    output logic                   o_valid,
    output logic signed [3*W+2:0]  o_xnum,
    output logic signed [3*W+2:0]  o_ynum,
    output logic signed [2*W+2:0]  o_den,
    output logic [7:0][W-1:0]      o_coord
);
    localparam int NW = 3*W + 3;
    localparam int DW = 2*W + 3;
    localparam int PW = 2*W + 2;

    logic [2:0] r_v;
    logic [2:0][7:0][W-1:0] r_c;

    // stage 1
    logic signed [2*W:0] r_det1, r_det2, n_det1, n_det2;
    logic signed [W:0]   r_dx1, r_dx2, r_dy1, r_dy2, n_dx1, n_dx2, n_dy1, n_dy2;

    always_comb begin
        n_det1 = $signed(i_coord[0]) * $signed(i_coord[3])
               - $signed(i_coord[1]) * $signed(i_coord[2]);
        n_det2 = $signed(i_coord[4]) * $signed(i_coord[7])
               - $signed(i_coord[5]) * $signed(i_coord[6]);
        n_dx1  = $signed(i_coord[0]) - $signed(i_coord[2]);
        n_dx2  = $signed(i_coord[4]) - $signed(i_coord[6]);
        n_dy1  = $signed(i_coord[1]) - $signed(i_coord[3]);
        n_dy2  = $signed(i_coord[5]) - $signed(i_coord[7]);
    end

    // stage 2: det = hi * 2^W + lo, lo unsigned
    logic signed [PW-1:0] r_xa_l, r_xa_h, r_xb_l, r_xb_h;
    logic signed [PW-1:0] r_ya_l, r_ya_h, r_yb_l, r_yb_h;
    logic signed [PW-1:0] r_da, r_db;
    logic signed [W:0]    d1_l, d2_l, d1_h, d2_h;

    always_comb begin
        d1_l = $signed({1'b0, r_det1[W-1:0]});
        d2_l = $signed({1'b0, r_det2[W-1:0]});
        d1_h = r_det1[2*W:W];
        d2_h = r_det2[2*W:W];
    end

    // stage 3
    logic signed [NW-1:0] n_xnum, n_ynum, e_xa, e_xb, e_ya, e_yb;
    logic signed [NW-1:0] t_xa_h, t_xb_h, t_ya_h, t_yb_h;
    logic signed [NW-1:0] t_xa_l, t_xb_l, t_ya_l, t_yb_l;
    logic signed [DW-1:0] n_den, e_da, e_db;

    always_comb begin
        t_xa_h = r_xa_h; t_xb_h = r_xb_h; t_ya_h = r_ya_h; t_yb_h = r_yb_h;
        t_xa_l = r_xa_l; t_xb_l = r_xb_l; t_ya_l = r_ya_l; t_yb_l = r_yb_l;
        e_xa   = (t_xa_h <<< W) + t_xa_l;
        e_xb   = (t_xb_h <<< W) + t_xb_l;
        e_ya   = (t_ya_h <<< W) + t_ya_l;
        e_yb   = (t_yb_h <<< W) + t_yb_l;
        n_xnum = e_xa - e_xb;
        n_ynum = e_ya - e_yb;
        e_da   = r_da;
        e_db   = r_db;
        n_den  = e_da - e_db;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c    <= {r_c[1:0], i_coord};
            r_det1 <= n_det1;
            r_det2 <= n_det2;
            r_dx1  <= n_dx1;
            r_dx2  <= n_dx2;
            r_dy1  <= n_dy1;
            r_dy2  <= n_dy2;
            r_xa_l <= d1_l * r_dx2;
            r_xa_h <= d1_h * r_dx2;
            r_xb_l <= d2_l * r_dx1;
            r_xb_h <= d2_h * r_dx1;
            r_ya_l <= d1_l * r_dy2;
            r_ya_h <= d1_h * r_dy2;
            r_yb_l <= d2_l * r_dy1;
            r_yb_h <= d2_h * r_dy1;
            r_da   <= r_dx1 * r_dy2;
            r_db   <= r_dy1 * r_dx2;
            o_xnum <= n_xnum;
            o_ynum <= n_ynum;
            o_den  <= n_den;
        end
    end

    assign o_valid = r_v[2];
    assign o_coord = r_c[2];

endmodule

// ----- src/sit_divider.sv -----
// ----------------------------------------------------------------------------
// sit_divider
// Magnitude and range check, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module sit_divider #(
    parameter int W = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [3*W+2:0]  i_xnum,
    input  logic signed [3*W+2:0]  i_ynum,
    input  logic signed [2*W+2:0]  i_den,
    input  logic [7:0][W-1:0]      i_coord,
    output sit_pkg::t_ctl          o_ctl,
    output logic [W:0]             o_qx,
    output logic [W:0]             o_qy,
    output logic                   o_negx,
    output logic                   o_negy,
    output logic                   o_hix,
    output logic                   o_hiy,
    output logic [7:0][W-1:0]      o_coord
);
    localparam int NW = 3*W + 3;
    localparam int DW = 2*W + 3;
    localparam int QB = W + 1;

    // magnitude stage
    logic                 r_pv, r_pz, r_pnx, r_pny;
    logic [NW-1:0]        r_pax, r_pay, n_ax, n_ay;
    logic [DW-1:0]        r_pd, n_d;
    logic [7:0][W-1:0]    r_pc;

    always_comb begin
        n_ax = i_xnum[NW-1] ? NW'(-i_xnum) : i_xnum;
        n_ay = i_ynum[NW-1] ? NW'(-i_ynum) : i_ynum;
        n_d  = i_den[DW-1]  ? DW'(-i_den)  : i_den;
    end

    // step stages, index 0 is the range check
    logic [QB:0]                r_v, r_z, r_nx, r_ny, r_hx, r_hy;
    logic [QB:0][NW-1:0]        r_rx, r_ry;
    logic [QB:0][QB-1:0]        r_qx, r_qy;
    logic [QB:0][DW-1:0]        r_d;
    logic [QB:0][7:0][W-1:0]    r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_pv   <= i_valid;
            r_v[0] <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pz    <= (i_den == '0);
            r_pnx   <= i_xnum[NW-1] ^ i_den[DW-1];
            r_pny   <= i_ynum[NW-1] ^ i_den[DW-1];
            r_pax   <= n_ax;
            r_pay   <= n_ay;
            r_pd    <= n_d;
            r_pc    <= i_coord;
            r_z[0]  <= r_pz;
            r_nx[0] <= r_pnx;
            r_ny[0] <= r_pny;
            r_hx[0] <= {1'b0, r_pax} >= {r_pd, {QB{1'b0}}};
            r_hy[0] <= {1'b0, r_pay} >= {r_pd, {QB{1'b0}}};
            r_rx[0] <= r_pax;
            r_ry[0] <= r_pay;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_d[0]  <= r_pd;
            r_c[0]  <= r_pc;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        localparam int SH = QB - k;
        logic [NW-1:0] ds;
        logic [NW:0]   tx, ty;

        assign ds = {{(NW-DW){1'b0}}, r_d[k-1]} << SH;
        assign tx = {1'b0, r_rx[k-1]} - {1'b0, ds};
        assign ty = {1'b0, r_ry[k-1]} - {1'b0, ds};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rx[k] <= tx[NW] ? r_rx[k-1] : tx[NW-1:0];
                r_ry[k] <= ty[NW] ? r_ry[k-1] : ty[NW-1:0];
                r_qx[k] <= r_qx[k-1] | ({{(QB-1){1'b0}}, ~tx[NW]} << SH);
                r_qy[k] <= r_qy[k-1] | ({{(QB-1){1'b0}}, ~ty[NW]} << SH);
                r_d[k]  <= r_d[k-1];
                r_z[k]  <= r_z[k-1];
                r_nx[k] <= r_nx[k-1];
                r_ny[k] <= r_ny[k-1];
                r_hx[k] <= r_hx[k-1];
                r_hy[k] <= r_hy[k-1];
                r_c[k]  <= r_c[k-1];
            end
        end
    end

    assign o_ctl.valid    = r_v[QB];
    assign o_ctl.den_zero = r_z[QB];
    assign o_qx    = r_qx[QB];
    assign o_qy    = r_qy[QB];
    assign o_negx  = r_nx[QB];
    assign o_negy  = r_ny[QB];
    assign o_hix   = r_hx[QB];
    assign o_hiy   = r_hy[QB];
    assign o_coord = r_c[QB];

endmodule

// ----- src/sit_finish.sv -----
// ----------------------------------------------------------------------------
// sit_finish
// Sign, saturation, bounding box test and the output register.
// ----------------------------------------------------------------------------
module sit_finish #(
    parameter int W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  sit_pkg::t_ctl      i_ctl,
    input  logic [W:0]         i_qx,
    input  logic [W:0]         i_qy,
    input  logic               i_negx,
    input  logic               i_negy,
    input  logic               i_hix,
    input  logic               i_hiy,
    input  logic [7:0][W-1:0]  i_coord,
    sit_out_if.source          o_res
);
    localparam logic [W:0] LIM = {2'b01, {(W-1){1'b0}}};

    logic [W:0]   mx, my, mnx, mny;
    logic         sx, sy;
    logic [W-1:0] n_px, n_py;

    always_comb begin
        sx   = i_hix || (i_negx ? (i_qx > LIM) : (i_qx > LIM - 1'b1));
        sy   = i_hiy || (i_negy ? (i_qy > LIM) : (i_qy > LIM - 1'b1));
        mx   = sx ? (i_negx ? LIM : LIM - 1'b1) : i_qx;
        my   = sy ? (i_negy ? LIM : LIM - 1'b1) : i_qy;
        mnx  = -mx;
        mny  = -my;
        n_px = i_negx ? mnx[W-1:0] : mx[W-1:0];
        n_py = i_negy ? mny[W-1:0] : my[W-1:0];
    end

    sit_pkg::t_ctl     r_ctl;
    logic [W-1:0]      r_px, r_py;
    logic              r_sat;
    logic [7:0][W-1:0] r_c;
    logic              r_ov;

    function automatic logic in_span(input logic [W-1:0] p, input logic [W-1:0] a,
                                     input logic [W-1:0] b);
        logic signed [W-1:0] lo, hi;
        lo = ($signed(a) < $signed(b)) ? a : b;
        hi = ($signed(a) < $signed(b)) ? b : a;
        return ($signed(p) >= lo) && ($signed(p) <= hi);
    endfunction

    logic hit;
    assign hit = !r_sat
              && in_span(r_px, r_c[0], r_c[2]) && in_span(r_py, r_c[1], r_c[3])
              && in_span(r_px, r_c[4], r_c[6]) && in_span(r_py, r_c[5], r_c[7]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_ov  <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
            r_ov  <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_px;
            r_py <= n_py;
            r_sat <= sx || sy;
            r_c  <= i_coord;
            if (r_ctl.den_zero) begin
                o_res.cross_x    <= '0;
                o_res.cross_y    <= '0;
                o_res.hit_status <= sit_pkg::HIT_NONE;
                o_res.saturated  <= 1'b0;
            end else begin
                o_res.cross_x    <= r_px;
                o_res.cross_y    <= r_py;
                o_res.hit_status <= hit ? sit_pkg::HIT_INSIDE : sit_pkg::HIT_OUTSIDE;
                o_res.saturated  <= r_sat;
            end
        end
    end

    assign o_res.valid = r_ov;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the segment intersection test: segment pairs go in through
// the input channel, an exact 192-bit predictor computes the crossing point,
// status and saturation flag, and every result transaction is compared in
// order with the predicted one. The input channel idles and the output channel stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW = 32;
    localparam int LATENCY = CW + 8;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef logic signed [CW-1:0] t_coord;
    typedef struct {
        t_coord x1, y1, x2, y2, x3, y3, x4, y4;
    } t_seg_pair;
    typedef struct {
        t_coord     cx;
        t_coord     cy;
        logic [1:0] status;
        logic       sat;
    } t_crossing;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     errors = 0;
    longint cycles = 0;
    bit     sink_busy = 1'b0;
    bit     stall_long = 1'b0;
    t_crossing crossings_due[$];

    sit_in_if  #(.W(CW)) seg_if ();
    sit_out_if #(.W(CW)) res_if ();

    segment_intersection_test #(.COORD_WIDTH(CW)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        seg_if.valid = 1'b0;
        seg_if.seg_a_start_x = '0;
        seg_if.seg_a_start_y = '0;
        seg_if.seg_a_end_x   = '0;
        seg_if.seg_a_end_y   = '0;
        seg_if.seg_b_start_x = '0;
        seg_if.seg_b_start_y = '0;
        seg_if.seg_b_end_x   = '0;
        seg_if.seg_b_end_y   = '0;
        res_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // signed truncating quotient, clamped to the coordinate range
    function automatic t_coord clamp_quot(logic signed [191:0] num,
                                          logic signed [191:0] den, ref bit sat);
        logic signed [191:0] q;
        q = num / den;
        if (q > 192'sh7FFFFFFF) begin
            sat = 1'b1;
            return t_coord'(32'h7FFFFFFF);
        end
        if (q < -192'sh80000000) begin
            sat = 1'b1;
            return t_coord'(32'h80000000);
        end
        return t_coord'(q[CW-1:0]);
    endfunction

    function automatic bit in_span(t_coord p, t_coord a, t_coord b);
        return (a <= b) ? (p >= a && p <= b) : (p >= b && p <= a);
    endfunction

    function automatic t_crossing predict_crossing(t_seg_pair s);
        logic signed [191:0] x1, y1, x2, y2, x3, y3, x4, y4;
        logic signed [191:0] det1, det2, dx1, dx2, dy1, dy2, xnum, ynum, den;
        t_crossing r;
        bit sat;
        x1 = s.x1; y1 = s.y1; x2 = s.x2; y2 = s.y2;
        x3 = s.x3; y3 = s.y3; x4 = s.x4; y4 = s.y4;
        det1 = x1 * y2 - y1 * x2;
        det2 = x3 * y4 - y3 * x4;
        dx1 = x1 - x2; dx2 = x3 - x4;
        dy1 = y1 - y2; dy2 = y3 - y4;
        xnum = det1 * dx2 - dx1 * det2;
        ynum = det1 * dy2 - dy1 * det2;
        den  = dx1 * dy2 - dy1 * dx2;
        r.cx = '0; r.cy = '0; r.status = sit_pkg::HIT_NONE; r.sat = 1'b0;
        if (den == 0)
            return r;
        sat = 1'b0;
        r.cx = clamp_quot(xnum, den, sat);
        r.cy = clamp_quot(ynum, den, sat);
        r.sat = sat;
        r.status = (!sat && in_span(r.cx, s.x1, s.x2) && in_span(r.cy, s.y1, s.y2)
                    && in_span(r.cx, s.x3, s.x4) && in_span(r.cy, s.y3, s.y4))
                   ? sit_pkg::HIT_INSIDE : sit_pkg::HIT_OUTSIDE;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(0, 2);
    endfunction

    // valid stays high into the next transaction when there is no gap
    task automatic send_pair(t_seg_pair s);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            seg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        crossings_due.push_back(predict_crossing(s));
        seg_if.valid         <= 1'b1;
        seg_if.seg_a_start_x <= s.x1;
        seg_if.seg_a_start_y <= s.y1;
        seg_if.seg_a_end_x   <= s.x2;
        seg_if.seg_a_end_y   <= s.y2;
        seg_if.seg_b_start_x <= s.x3;
        seg_if.seg_b_start_y <= s.y3;
        seg_if.seg_b_end_x   <= s.x4;
        seg_if.seg_b_end_y   <= s.y4;
        @(posedge i_clk);
        while (!seg_if.ready) @(posedge i_clk);
    endtask

    // result checker with random backpressure
    initial begin
        t_crossing want;
        int stall;
        @(posedge i_clk);
        forever begin
            stall = stall_long ? $urandom_range(0, 30) : gap_len();
            res_if.ready <= (stall == 0);
            @(posedge i_clk);
            if (stall != 0) begin
                repeat (stall - 1) @(posedge i_clk);
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
            while (!(res_if.valid && res_if.ready)) @(posedge i_clk);
            if (crossings_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction x=%0d y=%0d", $time,
                         res_if.cross_x, res_if.cross_y);
            end else begin
                want = crossings_due.pop_front();
                if (res_if.cross_x !== want.cx || res_if.cross_y !== want.cy ||
                    res_if.hit_status !== want.status || res_if.saturated !== want.sat) begin
                    errors++;
                    $display("%0t: expected x=%0d y=%0d st=%0d sat=%0d, got x=%0d y=%0d st=%0d sat=%0d",
                             $time, want.cx, want.cy, want.status, want.sat,
                             res_if.cross_x, res_if.cross_y,
                             res_if.hit_status, res_if.saturated);
                end
            end
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom);
            1: return t_coord'(32'h80000000 + $urandom_range(0, 3));
            2: return t_coord'(32'h7FFFFFFF - $urandom_range(0, 3));
            3: return t_coord'($signed($urandom_range(0, 2000)) - 1000);
            default: return t_coord'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
        endcase
    endfunction

    function automatic t_seg_pair pair_of(int a, int b, int c, int d,
                                          int e, int f, int g, int h);
        t_seg_pair s;
        s.x1 = a; s.y1 = b; s.x2 = c; s.y2 = d;
        s.x3 = e; s.y3 = f; s.x4 = g; s.y4 = h;
        return s;
    endfunction

    task automatic test_directed();
        localparam int ONE = 32'h10000;
        localparam int MAXC = 32'h7FFFFFFF;
        localparam int MINC = 32'h80000000;
        // crossing inside both segments
        send_pair(pair_of(0, 0, 4*ONE, 4*ONE, 0, 4*ONE, 4*ONE, 0));
        // crossing outside both segments
        send_pair(pair_of(0, 0, ONE, ONE, 10*ONE, 0, 9*ONE, ONE));
        // parallel and zero-length segments
        send_pair(pair_of(0, 0, ONE, ONE, ONE, 0, 2*ONE, ONE));
        send_pair(pair_of(5, 5, 5, 5, 0, 0, ONE, -ONE));
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
        // crossing at an endpoint
        send_pair(pair_of(0, 0, ONE, 0, ONE, 0, ONE, ONE));
        // extreme coordinates and further crossings
        send_pair(pair_of(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC));
        send_pair(pair_of(MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC));
        send_pair(pair_of(0, 0, ONE, 1, 0, 1, ONE, 2 + 1));
        send_pair(pair_of(0, 0, ONE, 1, 0, -1, ONE, -2 + 1));
        send_pair(pair_of(0, 0, -ONE, 1, 0, 1, -ONE, 3));
        send_pair(pair_of(MINC, 0, MAXC, 1, MINC, MAXC, MAXC, MINC));
        send_pair(pair_of(-1, -1, -1, 1, MINC, 0, MAXC, 0));
        send_pair(pair_of(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC));
        send_pair(pair_of(-1, -1, -1, -1, -1, -1, -1, -1));
    endtask

    task automatic test_random(int count);
        t_seg_pair s;
        repeat (count) begin
            s.x1 = rand_coord(); s.y1 = rand_coord();
            s.x2 = rand_coord(); s.y2 = rand_coord();
            s.x3 = rand_coord(); s.y3 = rand_coord();
            s.x4 = rand_coord(); s.y4 = rand_coord();
            case ($urandom_range(0, 9))
                0: begin s.x3 = s.x1 + (s.x2 - s.x1); s.y3 = s.y2;
                         s.x4 = s.x3 + (s.x2 - s.x1); s.y4 = s.y3 + (s.y2 - s.y1); end
                1: begin s.x2 = s.x1; s.y2 = s.y1; end
                default: ;
            endcase
            send_pair(s);
        end
    endtask

    task automatic test_back_to_back(int count);
        stall_long = 1'b1;
        test_random(count);
        stall_long = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1400);
        test_back_to_back(300);
        test_random(250);
        seg_if.valid <= 1'b0;
        while (crossings_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
